[src/ygca_pkg.sv]
// Shared constants, coefficients and clamp for the YUV gain color adjust block.
// No dependencies; used by the datapath top level and its port checker.
package ygca_pkg;

  // Pixel latency from an accepted start to its done strobe
  localparam int PipeDepth = 6;

  // Configuration register indexes
  localparam logic [1:0] RegGainLuma     = 2'd0;
  localparam logic [1:0] RegGainBlueDiff = 2'd1;
  localparam logic [1:0] RegGainRedDiff  = 2'd2;

  localparam logic [7:0] GainReset = 8'd100;

  // Q14 coefficient magnitudes; luma weights sum to exactly 1.0
  localparam logic [22:0] CoefYr = 23'd4899;
  localparam logic [22:0] CoefYg = 23'd9617;
  localparam logic [22:0] CoefYb = 23'd1868;

  localparam logic signed [17:0] CoefU  = 18'sd8077;
  localparam logic signed [17:0] CoefV  = 18'sd14369;
  localparam logic signed [17:0] CoefRv = 18'sd18682;
  localparam logic signed [17:0] CoefGu = 18'sd6455;
  localparam logic signed [17:0] CoefGv = 18'sd9519;
  localparam logic signed [17:0] CoefBu = 18'sd33233;

  // Divide by 100: bias keeps the dividend positive (50 rounds half up,
  // 100 * 2^24 is removed again after the divide), then reciprocal multiply
  localparam logic [31:0]        GainBias  = 32'd1677721650;
  localparam logic [31:0]        DivMagic  = 32'd1374389535;
  localparam int                 DivShift  = 37;
  localparam logic signed [26:0] QuotBias  = 27'sd16777216;

  localparam logic signed [28:0] ChanTop = 29'sd4177920;  // 255.0 in Q14

  typedef logic signed [28:0] chan_q14_t;

  function automatic logic [7:0] clamp_chan(input chan_q14_t v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > ChanTop) begin
      res = 8'd255;
    end else begin
      res = v[21:14];
    end
    return res;
  endfunction

endpackage

[src/yuv_gain_color_adjust.sv]
// RGB -> analog YUV -> per-component percent gain -> RGB, clamped to 8 bits.
// Depends on ygca_pkg for coefficients, register indexes and the clamp.
//
// One pixel is taken on each clock with start high (busy stays low), and its
// result appears on red_out/green_out/blue_out for exactly one cycle with done
// high. Throughput is one pixel per clock. The datapath has six register
// stages: luma sum, chroma multiply, gain multiply, divide by 100 through a
// reciprocal multiply, inverse matrix multiply, sum and clamp.
// Gain registers are taken over the write port and must only change while no
// pixel is in flight.
module yuv_gain_color_adjust (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output logic       done,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out
);

  logic [7:0] gain_luma;
  logic [7:0] gain_blue_diff;
  logic [7:0] gain_red_diff;

  logic [ygca_pkg::PipeDepth-1:0] valid;

  assign busy = 1'b0;
  assign done = valid[ygca_pkg::PipeDepth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_luma      <= ygca_pkg::GainReset;
      gain_blue_diff <= ygca_pkg::GainReset;
      gain_red_diff  <= ygca_pkg::GainReset;
    end else if (wr_en) begin
      unique case (wr_index)
        ygca_pkg::RegGainLuma:     gain_luma      <= wr_data;
        ygca_pkg::RegGainBlueDiff: gain_blue_diff <= wr_data;
        ygca_pkg::RegGainRedDiff:  gain_red_diff  <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[ygca_pkg::PipeDepth-2:0], start & ~busy};
    end
  end

  // Stage 1: luma in Q14
  logic [22:0] y1;
  logic [7:0]  r1;
  logic [7:0]  b1;

  always_ff @(posedge clk) begin
    y1 <= 23'(red_in) * ygca_pkg::CoefYr + 23'(green_in) * ygca_pkg::CoefYg
        + 23'(blue_in) * ygca_pkg::CoefYb;
    r1 <= red_in;
    b1 <= blue_in;
  end

  // Stage 2: color differences scaled to U and V, rounded to Q14
  logic signed [23:0] du;
  logic signed [23:0] dv;
  logic signed [38:0] pu_m;
  logic signed [38:0] pv_m;
  logic signed [38:0] pu_r;
  logic signed [38:0] pv_r;
  logic [22:0]        y2;
  logic signed [22:0] u2;
  logic signed [22:0] v2;

  assign du   = $signed({2'b00, b1, 14'd0}) - $signed({1'b0, y1});
  assign dv   = $signed({2'b00, r1, 14'd0}) - $signed({1'b0, y1});
  assign pu_m = 39'(du) * 39'(ygca_pkg::CoefU);
  assign pv_m = 39'(dv) * 39'(ygca_pkg::CoefV);
  assign pu_r = pu_m + 39'sd8192;
  assign pv_r = pv_m + 39'sd8192;

  always_ff @(posedge clk) begin
    y2 <= y1;
    u2 <= pu_r[36:14];
    v2 <= pv_r[36:14];
  end

  // Stage 3: multiply by gain, bias so the divide sees a positive dividend
  logic [31:0]        py_m;
  logic signed [31:0] pgu_m;
  logic signed [31:0] pgv_m;
  logic [31:0]        ny3;
  logic [31:0]        nu3;
  logic [31:0]        nv3;

  assign py_m  = 32'(y2) * 32'(gain_luma);
  assign pgu_m = 32'(u2) * $signed({24'd0, gain_blue_diff});
  assign pgv_m = 32'(v2) * $signed({24'd0, gain_red_diff});

  always_ff @(posedge clk) begin
    ny3 <= py_m + ygca_pkg::GainBias;
    nu3 <= unsigned'(pgu_m) + ygca_pkg::GainBias;
    nv3 <= unsigned'(pgv_m) + ygca_pkg::GainBias;
  end

  // Stage 4: exact floor divide by 100 through the reciprocal
  logic [63:0] qy_m;
  logic [63:0] qu_m;
  logic [63:0] qv_m;
  logic [25:0] qy4;
  logic [25:0] qu4;
  logic [25:0] qv4;

  assign qy_m = 64'(ny3) * 64'(ygca_pkg::DivMagic);
  assign qu_m = 64'(nu3) * 64'(ygca_pkg::DivMagic);
  assign qv_m = 64'(nv3) * 64'(ygca_pkg::DivMagic);

  always_ff @(posedge clk) begin
    qy4 <= qy_m[ygca_pkg::DivShift+25:ygca_pkg::DivShift];
    qu4 <= qu_m[ygca_pkg::DivShift+25:ygca_pkg::DivShift];
    qv4 <= qv_m[ygca_pkg::DivShift+25:ygca_pkg::DivShift];
  end

  // Stage 5: remove the divide bias, inverse matrix products rounded to Q14
  logic signed [26:0] yg_w;
  logic signed [26:0] ug_w;
  logic signed [26:0] vg_w;
  logic signed [25:0] ug;
  logic signed [25:0] vg;
  logic signed [42:0] prv_r;
  logic signed [42:0] pgu_r;
  logic signed [42:0] pgv_r;
  logic signed [42:0] pbu_r;
  logic signed [25:0] yg5;
  logic signed [26:0] rv5;
  logic signed [26:0] gu5;
  logic signed [26:0] gv5;
  logic signed [26:0] bu5;

  assign yg_w  = $signed({1'b0, qy4}) - ygca_pkg::QuotBias;
  assign ug_w  = $signed({1'b0, qu4}) - ygca_pkg::QuotBias;
  assign vg_w  = $signed({1'b0, qv4}) - ygca_pkg::QuotBias;
  assign ug    = ug_w[25:0];
  assign vg    = vg_w[25:0];
  assign prv_r = 43'(vg) * 43'(ygca_pkg::CoefRv) + 43'sd8192;
  assign pgu_r = 43'(ug) * 43'(ygca_pkg::CoefGu) + 43'sd8192;
  assign pgv_r = 43'(vg) * 43'(ygca_pkg::CoefGv) + 43'sd8192;
  assign pbu_r = 43'(ug) * 43'(ygca_pkg::CoefBu) + 43'sd8192;

  always_ff @(posedge clk) begin
    yg5 <= yg_w[25:0];
    rv5 <= prv_r[40:14];
    gu5 <= pgu_r[40:14];
    gv5 <= pgv_r[40:14];
    bu5 <= pbu_r[40:14];
  end

  // Stage 6: sum back to RGB and clamp
  ygca_pkg::chan_q14_t ro;
  ygca_pkg::chan_q14_t go;
  ygca_pkg::chan_q14_t bo;

  assign ro = 29'(yg5) + 29'(rv5);
  assign go = 29'(yg5) - 29'(gu5) - 29'(gv5);
  assign bo = 29'(yg5) + 29'(bu5);

  always_ff @(posedge clk) begin
    red_out   <= ygca_pkg::clamp_chan(ro);
    green_out <= ygca_pkg::clamp_chan(go);
    blue_out  <= ygca_pkg::clamp_chan(bo);
  end

endmodule

[src/ygca_check.sv]
// Port-level checker for yuv_gain_color_adjust, bound to the top level.
// Depends on ygca_pkg for the pixel latency.
module ygca_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] red_in,
  input logic [7:0] green_in,
  input logic [7:0] blue_in,
  input logic       done,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);

  // Every done traces back to an item accepted one latency earlier
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ygca_pkg::PipeDepth))
    else $error("done without an accepted item");

  // An item accepted with reset low throughout is delivered
  assert property (@(posedge clk)
    ($past(start && !busy, ygca_pkg::PipeDepth) && !rst
      && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
      && !$past(rst, 4) && !$past(rst, 5) && !$past(rst, 6)) |-> done)
    else $error("accepted item lost");

  // Black stays black at any gain
  assert property (@(posedge clk) disable iff (rst)
    (done && $past(red_in == 8'd0 && green_in == 8'd0 && blue_in == 8'd0,
      ygca_pkg::PipeDepth))
    |-> (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0))
    else $error("black pixel not preserved");

endmodule

bind yuv_gain_color_adjust ygca_check u_ygca_check (.*);

[verif/ygca_pixel_checker.sv]
// Pixel checker for yuv_gain_color_adjust: tracks gain writes, predicts each accepted pixel
// and compares every done strobe against the oldest prediction, field by field.
// Depends on ygca_pkg for register indexes, reset gain and the Q14 coefficients.
module ygca_pixel_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  input  logic       done,
  input  logic [7:0] red_out,
  input  logic [7:0] green_out,
  input  logic [7:0] blue_out,
  output int         outstanding,
  output int         errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic [7:0] luma_gain;
  logic [7:0] blue_gain;
  logic [7:0] red_gain;
  pixel_t     expected_pixels[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    luma_gain   = ygca_pkg::GainReset;
    blue_gain   = ygca_pkg::GainReset;
    red_gain    = ygca_pkg::GainReset;
  end

  task automatic flag(input string msg);
    errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // Q14 value times Q14 coefficient, rounded half up back to Q14
  function automatic longint coef_mul(input longint x, input longint coef);
    return (x * coef + 8192) >>> 14;
  endfunction

  // x * gain / 100, ties toward plus infinity
  function automatic longint percent_scale(input longint x, input logic [7:0] gain);
    longint num;
    longint quo;
    num = 2 * x * longint'(gain) + 100;
    quo = num / 200;
    if (num < 0 && quo * 200 != num) begin
      quo = quo - 1;
    end
    return quo;
  endfunction

  function automatic logic [7:0] saturate_channel(input longint v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > longint'(ygca_pkg::ChanTop)) begin
      res = 8'd255;
    end else begin
      res = v[21:14];
    end
    return res;
  endfunction

  function automatic pixel_t adjust_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    longint luma;
    longint u_diff;
    longint v_diff;
    longint luma_s;
    longint u_s;
    longint v_s;
    pixel_t res;
    luma   = longint'(ygca_pkg::CoefYr) * longint'(r)
           + longint'(ygca_pkg::CoefYg) * longint'(g)
           + longint'(ygca_pkg::CoefYb) * longint'(b);
    u_diff = coef_mul((longint'(b) <<< 14) - luma, longint'(ygca_pkg::CoefU));
    v_diff = coef_mul((longint'(r) <<< 14) - luma, longint'(ygca_pkg::CoefV));
    luma_s = percent_scale(luma, luma_gain);
    u_s    = percent_scale(u_diff, blue_gain);
    v_s    = percent_scale(v_diff, red_gain);
    res.red   = saturate_channel(luma_s + coef_mul(v_s, longint'(ygca_pkg::CoefRv)));
    res.green = saturate_channel(luma_s - coef_mul(u_s, longint'(ygca_pkg::CoefGu))
                                 - coef_mul(v_s, longint'(ygca_pkg::CoefGv)));
    res.blue  = saturate_channel(luma_s + coef_mul(u_s, longint'(ygca_pkg::CoefBu)));
    return res;
  endfunction

  always @(posedge clk) begin : watch_ports
    pixel_t want;
    int     delta;
    delta = 0;
    if (rst) begin
      luma_gain = ygca_pkg::GainReset;
      blue_gain = ygca_pkg::GainReset;
      red_gain  = ygca_pkg::GainReset;
      expected_pixels.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (expected_pixels.size() == 0) begin
          flag($sformatf("result %0d/%0d/%0d with no pixel outstanding",
                         red_out, green_out, blue_out));
        end else begin
          want  = expected_pixels.pop_front();
          delta = delta - 1;
          if (red_out !== want.red) begin
            flag($sformatf("red_out %0d, expected %0d", red_out, want.red));
          end
          if (green_out !== want.green) begin
            flag($sformatf("green_out %0d, expected %0d", green_out, want.green));
          end
          if (blue_out !== want.blue) begin
            flag($sformatf("blue_out %0d, expected %0d", blue_out, want.blue));
          end
        end
      end
      if (start && !busy) begin
        expected_pixels.push_back(adjust_pixel(red_in, green_in, blue_in));
        delta = delta + 1;
      end
      // writes land after this edge's prediction
      if (wr_en) begin
        case (wr_index)
          ygca_pkg::RegGainLuma:     luma_gain = wr_data;
          ygca_pkg::RegGainBlueDiff: blue_gain = wr_data;
          ygca_pkg::RegGainRedDiff:  red_gain  = wr_data;
          default: ;
        endcase
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

[verif/testbench.sv]
// Top of the yuv_gain_color_adjust testbench: clock, reset, gain phases and bursty pixel stimulus.
// Depends on ygca_pkg, the block itself and ygca_pixel_checker, which predicts and compares.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegSpare     = 2'd3;
  localparam int         NumPhases    = 9;
  localparam int         PhaseItems   = 200;
  localparam int         NumCorners   = 20;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       wr_en;
  logic [1:0] wr_index;
  logic [7:0] wr_data;
  logic       done;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  int         outstanding;
  int         errors;

  // gains per phase: luma, blue diff, red diff; phase 0 runs on reset values
  logic [23:0] gain_plan [7] = '{24'h646464, 24'h000000, 24'hFFFFFF, 24'h00FF00,
                                 24'hFF00FF, 24'h6400FF, 24'h01FE80};

  logic [23:0] corner_pixels [NumCorners] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F,
    24'h010101, 24'hFEFEFE, 24'h01FE80, 24'hAA55AA, 24'h55AA55,
    24'hFF7F00, 24'h00807F, 24'h0F0FF0, 24'hF0F00F, 24'h123456};

  yuv_gain_color_adjust u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .done      (done),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  ygca_pixel_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .done        (done),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .outstanding (outstanding),
    .errors      (errors)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // favor the channel extremes, where the clamp works hardest
  function automatic logic [7:0] pick_channel();
    logic [7:0] res;
    case ($urandom_range(0, 7))
      0:       res = 8'd0;
      1:       res = 8'd255;
      default: res = 8'($urandom_range(0, 255));
    endcase
    return res;
  endfunction

  // hold start with the pixel until the block takes it
  task automatic send_pixel(input logic [23:0] rgb);
    start    <= 1'b1;
    red_in   <= rgb[23:16];
    green_in <= rgb[15:8];
    blue_in  <= rgb[7:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and wait out every pixel in flight
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (ygca_pkg::PipeDepth + 2) @(posedge clk);
  endtask

  task automatic load_gains(input logic [23:0] gains);
    logic [1:0] order [4];
    logic [7:0] value [4];
    order = '{ygca_pkg::RegGainLuma, ygca_pkg::RegGainBlueDiff, ygca_pkg::RegGainRedDiff,
              RegSpare};
    value = '{gains[23:16], gains[15:8], gains[7:0], 8'($urandom_range(0, 255))};
    for (int k = 0; k < 4; k++) begin
      wr_en    <= 1'b1;
      wr_index <= order[k];
      wr_data  <= value[k];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [23:0] rgb;
    int          burst_left;
    rst      <= 1'b1;
    start    <= 1'b0;
    red_in   <= 8'd0;
    green_in <= 8'd0;
    blue_in  <= 8'd0;
    wr_en    <= 1'b0;
    wr_index <= ygca_pkg::RegGainLuma;
    wr_data  <= 8'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst_left = $urandom_range(1, 12);
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        load_gains(phase < 7 ? gain_plan[phase] : 24'($urandom()));
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 0 && n < NumCorners) begin
          rgb = corner_pixels[n];
        end else begin
          rgb = {pick_channel(), pick_channel(), pick_channel()};
        end
        send_pixel(rgb);
        burst_left--;
        if (n == PhaseItems - 1 || (phase == 3 && n == PhaseItems / 2)) begin
          drain_pipe();
        end else if (burst_left <= 0) begin
          start    <= 1'b0;
          red_in   <= 8'($urandom_range(0, 255));
          green_in <= 8'($urandom_range(0, 255));
          blue_in  <= 8'($urandom_range(0, 255));
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
        end
      end
    end

    repeat (ygca_pkg::PipeDepth + 4) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
